[hw/rtl/float64_approx_equal_defines.svh]
// Assertion macros shared by the float64 approximate-equality block.
`ifndef FLOAT64_APPROX_EQUAL_DEFINES_SVH
`define FLOAT64_APPROX_EQUAL_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, quiet during reset.
`define F64AE_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock, quiet during reset.
`define F64AE_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/f64ae_pkg.sv]
// Types and constants of the float64 approximate-equality block.
`timescale 1ns / 1ps
`default_nettype none
package f64ae_pkg;

  typedef enum logic [3:0] {
    VERD_NAN      = 4'd0,
    VERD_INF      = 4'd1,
    VERD_ZERO     = 4'd2,
    VERD_SUBNORM  = 4'd3,
    VERD_ABS      = 4'd4,
    VERD_REL      = 4'd5,
    VERD_SIGN     = 4'd6,
    VERD_ULP      = 4'd7,
    VERD_NOT_EQ   = 4'd8
  } verdict_e;

  localparam logic [1:0]  CFG_IDX_TOL  = 2'd0;
  localparam logic [1:0]  CFG_IDX_ULPS = 2'd1;

  localparam logic [62:0] TOL_RESET  = 63'h3CD203AF9EE75616;
  localparam logic [15:0] ULPS_RESET = 16'd4;

  localparam logic [10:0] EXP_ALL = 11'h7FF;
  localparam logic [62:0] INF_MAG = 63'h7FF0000000000000;

endpackage
`default_nettype wire

[hw/rtl/f64ae_absdiff.sv]
// Rounded magnitude of the difference of two finite, non-subnormal doubles.
`timescale 1ns / 1ps
`default_nettype none
module f64ae_absdiff (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [62:0] diff_o
);
  import f64ae_pkg::*;

  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd56;
    hit = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 6'(55 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  logic [62:0]  ma, mb, mx, my;
  logic [10:0]  ex, ey, d, lim;
  logic [52:0]  sigx, sigy;
  logic [5:0]   dsh, lz, shl;
  logic [119:0] win;
  logic [55:0]  wx, ys, n;
  logic [56:0]  r;
  logic [11:0]  en;
  logic         rnd;
  logic [63:0]  sum;

  always_comb begin
    ma   = a_i[62:0];
    mb   = b_i[62:0];
    mx   = (mb > ma) ? mb : ma;
    my   = (mb > ma) ? ma : mb;
    // Zero carries exponent field 0 and takes the frame of exponent 1.
    ex   = (mx[62:52] == 11'd0) ? 11'd1 : mx[62:52];
    ey   = (my[62:52] == 11'd0) ? 11'd1 : my[62:52];
    sigx = {(mx[62:52] != 11'd0), mx[51:0]};
    sigy = {(my[62:52] != 11'd0), my[51:0]};
    d    = ex - ey;
    dsh  = (d > 11'd63) ? 6'd63 : d[5:0];
    win  = {sigy, 3'b000, 64'd0} >> dsh;
    ys   = win[119:64] | {55'd0, |win[63:0]};
    wx   = {sigx, 3'b000};
    // Equal signs subtract magnitudes, different signs add them.
    if (a_i[63] == b_i[63]) r = {1'b0, wx} - {1'b0, ys};
    else                    r = {1'b0, wx} + {1'b0, ys};
    lz   = lzc56(r[55:0]);
    lim  = ex - 11'd1;
    shl  = ({5'd0, lz} > lim) ? lim[5:0] : lz;
    if (r[56]) begin
      n  = {r[56:2], r[1] | r[0]};
      en = {1'b0, ex} + 12'd1;
    end else begin
      n  = r[55:0] << shl;
      en = {1'b0, ex} - {6'd0, shl};
      if (!n[55]) en = 12'd0;
    end
    rnd = n[2] & (n[1] | n[0] | n[3]);
    sum = {en, n[54:3]} + {63'd0, rnd};
    diff_o = (sum >= {1'b0, INF_MAG}) ? INF_MAG : sum[62:0];
  end

endmodule
`default_nettype wire

[hw/rtl/f64ae_decide.sv]
// Rule chain that classifies an operand pair and gives the equality verdict.
`timescale 1ns / 1ps
`default_nettype none
module f64ae_decide (
  input  logic [63:0]         a_i,
  input  logic [63:0]         b_i,
  input  logic [62:0]         tol_i,
  input  logic [15:0]         ulps_i,
  output logic                eq_o,
  output f64ae_pkg::verdict_e verdict_o
);
  import f64ae_pkg::*;

  logic [62:0]  ma, mb, big, diff, scaled, ulp_gap;
  logic         a_nan, b_nan, a_inf, b_inf, a_sub, b_sub, tol_nan;
  logic [10:0]  ebig;
  logic [5:0]   sh;
  logic [105:0] t;
  logic         g, st, rnd;

  f64ae_absdiff u_absdiff (
    .a_i    (a_i),
    .b_i    (b_i),
    .diff_o (diff)
  );

  always_comb begin
    ma    = a_i[62:0];
    mb    = b_i[62:0];
    a_nan = (ma[62:52] == EXP_ALL) && (ma[51:0] != 52'd0);
    b_nan = (mb[62:52] == EXP_ALL) && (mb[51:0] != 52'd0);
    a_inf = (ma[62:52] == EXP_ALL);
    b_inf = (mb[62:52] == EXP_ALL);
    a_sub = (ma[62:52] == 11'd0) && (ma != 63'd0);
    b_sub = (mb[62:52] == 11'd0) && (mb != 63'd0);
    tol_nan = (tol_i[62:52] == EXP_ALL) && (tol_i[51:0] != 52'd0);

    // Larger magnitude times 2^-52, rounded to nearest even when it
    // falls into the subnormal range.
    big  = (ma >= mb) ? ma : mb;
    ebig = big[62:52];
    sh   = 6'(7'd53 - {1'b0, ebig[5:0]});
    t    = {1'b1, big[51:0], 53'd0} >> sh;
    g    = t[52];
    st   = |t[51:0];
    rnd  = g & (st | t[53]);
    if (ebig > 11'd52) scaled = big - {11'd52, 52'd0};
    else               scaled = {10'd0, t[105:53]} + {62'd0, rnd};

    ulp_gap = (ma >= mb) ? (ma - mb) : (mb - ma);

    priority if (a_nan || b_nan) begin
      eq_o = 1'b0; verdict_o = VERD_NAN;
    end else if (a_inf || b_inf) begin
      eq_o = (a_i == b_i); verdict_o = VERD_INF;
    end else if (ma == 63'd0 && mb == 63'd0) begin
      eq_o = 1'b1; verdict_o = VERD_ZERO;
    end else if (a_sub || b_sub) begin
      eq_o = 1'b0; verdict_o = VERD_SUBNORM;
    end else if (!tol_nan && (diff < tol_i)) begin
      eq_o = 1'b1; verdict_o = VERD_ABS;
    end else if (diff < scaled) begin
      eq_o = 1'b1; verdict_o = VERD_REL;
    end else if (a_i[63] != b_i[63]) begin
      eq_o = 1'b0; verdict_o = VERD_SIGN;
    end else if (ulp_gap <= {47'd0, ulps_i}) begin
      eq_o = 1'b1; verdict_o = VERD_ULP;
    end else begin
      eq_o = 1'b0; verdict_o = VERD_NOT_EQ;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/float64_approx_equal.sv]
// Top level of the float64 approximate-equality comparator.
`timescale 1ns / 1ps
`default_nettype none
// Usage
// An operand pair (a_bits_i, b_bits_i) is taken at a rising edge where
// start_i is high and busy_o is low. busy_o is always low: a new pair may
// be started in every cycle, so the sustained rate is one pair per cycle.
// The pair is captured in an input register, judged by one pass of
// combinational logic (a rounded double subtractor plus the rule chain),
// and the verdict is captured in a result register. The result appears on
// approx_equal_o and verdict_o from the result register, marked by done_o
// for exactly one cycle; the receiver cannot stall, so each result must be
// taken then. Configuration writes use their own valid/ready channel
// (cfg_ready_o is always high). Index 0 sets the absolute tolerance
// pattern, index 1 the ULP limit; other indices are ignored. Write only
// while no item is in flight. Reset loads a tolerance of 1e-15 and a ULP
// limit of 4, and clears both pipeline valid flags, so no stray result is
// signalled.
module float64_approx_equal (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [63:0]         a_bits_i,
  input  logic [63:0]         b_bits_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  output logic                done_o,
  output logic                approx_equal_o,
  output f64ae_pkg::verdict_e verdict_o
);
  import f64ae_pkg::*;

  logic [62:0] tol_q;
  logic [15:0] ulps_q;
  logic        in_vld_q;
  logic [63:0] a_q, b_q;
  logic        done_q;
  logic        eq_q, eq_d;
  verdict_e    verdict_q, verdict_d;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= TOL_RESET;
      ulps_q <= ULPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_IDX_TOL)  tol_q  <= cfg_data_i[62:0];
      if (cfg_index_i == CFG_IDX_ULPS) ulps_q <= cfg_data_i[15:0];
    end
  end

  // Valid flags of the two register stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
      done_q   <= in_vld_q;
    end
  end

  // Operand and result payload registers.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      a_q <= a_bits_i;
      b_q <= b_bits_i;
    end
    if (in_vld_q) begin
      eq_q      <= eq_d;
      verdict_q <= verdict_d;
    end
  end

  f64ae_decide u_decide (
    .a_i       (a_q),
    .b_i       (b_q),
    .tol_i     (tol_q),
    .ulps_i    (ulps_q),
    .eq_o      (eq_d),
    .verdict_o (verdict_d)
  );

  assign done_o         = done_q;
  assign approx_equal_o = eq_q;
  assign verdict_o      = verdict_q;

`include "float64_approx_equal_defines.svh"

  `F64AE_ASSERT_NXT(a_item_gives_result, in_vld_q, done_o, "captured pair gave no result")
  `F64AE_ASSERT_IMP(a_equal_verdicts, done_o && approx_equal_o, (verdict_o != VERD_NAN) && (verdict_o != VERD_SUBNORM) && (verdict_o != VERD_SIGN) && (verdict_o != VERD_NOT_EQ), "equal result with a rejecting verdict")
  `F64AE_ASSERT_IMP(a_reject_verdicts, done_o && !approx_equal_o, (verdict_o != VERD_ZERO) && (verdict_o != VERD_ABS) && (verdict_o != VERD_REL) && (verdict_o != VERD_ULP), "unequal result with an accepting verdict")

endmodule
`default_nettype wire

[tb/tb_float64_approx_equal.sv]
// Self-checking testbench for the float64 approximate-equality comparator.
`timescale 1ns / 1ps
module tb_float64_approx_equal;
  import f64ae_pkg::*;

  // One operand pair as the sender offers it.
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } pair_t;

  // One verdict as the block should report it.
  typedef struct packed {
    logic     eq;
    verdict_e verd;
  } judgement_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [63:0] a_bits_i = '0;
  logic [63:0] b_bits_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        busy_o;
  logic        cfg_ready_o;
  logic        done_o;
  logic        approx_equal_o;
  verdict_e    verdict_o;

  // Pairs waiting to be started, and verdicts waiting to come back.
  pair_t      pairs_pending[$];
  judgement_t verdicts_due[$];

  // Our own copy of the two configuration registers.
  logic [62:0] tol_q = TOL_RESET;
  logic [15:0] ulps_q = ULPS_RESET;

  int  errors = 0;
  int  pairs_started = 0;
  int  verdicts_seen = 0;
  int  cfg_writes = 0;
  bit  hold_off = 1'b0;
  int  verd_hits[9];

  always #2 clk_i = ~clk_i;

  float64_approx_equal u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .a_bits_i       (a_bits_i),
    .b_bits_i       (b_bits_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .approx_equal_o (approx_equal_o),
    .verdict_o      (verdict_o)
  );

  // Works out the verdict for one pair under the current registers. The
  // subtraction and the scaling are done on reals, which the simulator
  // evaluates as IEEE doubles with round-to-nearest-even.
  function automatic judgement_t judge(input logic [63:0] a, input logic [63:0] b);
    judgement_t  j;
    logic [62:0] ma, mb;
    logic [10:0] ea, eb;
    logic        a_nan, b_nan;
    logic [63:0] diff_bits, ulp_gap;
    real         mag_diff, tol, big, scaled;
    ma = a[62:0];
    mb = b[62:0];
    ea = a[62:52];
    eb = b[62:52];
    a_nan = (ea == EXP_ALL) && (a[51:0] != '0);
    b_nan = (eb == EXP_ALL) && (b[51:0] != '0);
    j.eq = 1'b0;
    if (a_nan || b_nan) begin
      j.verd = VERD_NAN;
    end else if (ea == EXP_ALL || eb == EXP_ALL) begin
      // Infinities only: equal exactly when the patterns are identical.
      j.verd = VERD_INF;
      j.eq = (a == b);
    end else if (ma == '0 && mb == '0) begin
      j.verd = VERD_ZERO;
      j.eq = 1'b1;
    end else if ((ea == '0 && ma != '0) || (eb == '0 && mb != '0)) begin
      j.verd = VERD_SUBNORM;
    end else begin
      diff_bits = $realtobits($bitstoreal(a) - $bitstoreal(b));
      mag_diff = $bitstoreal({1'b0, diff_bits[62:0]});
      tol = $bitstoreal({1'b0, tol_q});
      big = $bitstoreal({1'b0, (ma >= mb) ? ma : mb});
      scaled = big * $bitstoreal(64'h3CB0000000000000);
      ulp_gap = (ma >= mb) ? {1'b0, ma - mb} : {1'b0, mb - ma};
      if (mag_diff < tol) begin
        j.verd = VERD_ABS;
        j.eq = 1'b1;
      end else if (mag_diff < scaled) begin
        j.verd = VERD_REL;
        j.eq = 1'b1;
      end else if (a[63] != b[63]) begin
        j.verd = VERD_SIGN;
      end else if (ulp_gap <= {48'd0, ulps_q}) begin
        j.verd = VERD_ULP;
        j.eq = 1'b1;
      end else begin
        j.verd = VERD_NOT_EQ;
      end
    end
    return j;
  endfunction

  // A normal operand with its exponent anywhere, near the tolerance, near
  // one or extreme, so the absolute, relative and ULP rules get exercised.
  function automatic logic [63:0] rand_normal();
    logic [10:0] e;
    case ($urandom_range(0, 3))
      0: e = 11'($urandom_range(1, 2046));
      1: e = 11'($urandom_range(16'h3C0, 16'h3E0));
      2: e = 11'($urandom_range(16'h3F0, 16'h410));
      default: e = ($urandom_range(0, 1) != 0) ? 11'd1 : 11'd2046;
    endcase
    return {1'($urandom), e, 20'($urandom), 32'($urandom)};
  endfunction

  // Operand of an arbitrary class, used for noise.
  function automatic logic [63:0] rand_any();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v[62:52] = EXP_ALL;
      1: v[62:52] = '0;
      2: v[62:0] = '0;
      3: v[62:0] = INF_MAG;
      default: ;
    endcase
    return v;
  endfunction

  // Most random pairs are close neighbours with random content; the rest
  // is unrelated noise.
  function automatic pair_t rand_pair();
    pair_t p;
    p.a = rand_normal();
    case ($urandom_range(0, 9))
      0, 1, 2: p.b = p.a + 64'($urandom_range(0, 8));
      3:       p.b = p.a - 64'($urandom_range(0, 70000));
      4:       p.b = p.a ^ 64'(1) << $urandom_range(0, 51);
      5:       p.b = {~p.a[63], p.a[62:0] + 63'($urandom_range(0, 3))};
      6:       p.b = p.a;
      7:       p.b = rand_normal();
      8:       p.b = rand_any();
      default: begin
        p.a = rand_any();
        p.b = rand_any();
      end
    endcase
    if ($urandom_range(0, 1) != 0) begin
      p = '{a: p.b, b: p.a};
    end
    return p;
  endfunction

  // Driver. A start transfer happens at an edge with start_i high and
  // busy_o low; the expectation is recorded there. The next offer is then
  // decided once, so start_i gets a single assignment per edge. Idling is
  // switched off for a stretch in the middle of the run.
  always @(posedge clk_i) begin
    bit idle;
    if (start_i && !busy_o) begin
      verdicts_due.push_back(judge(a_bits_i, b_bits_i));
      void'(pairs_pending.pop_front());
      pairs_started <= pairs_started + 1;
    end
    idle = ($urandom_range(0, 99) < 23) && !(pairs_started > 500 && pairs_started < 800);
    if (rst_ni && !hold_off && !idle && pairs_pending.size() != 0) begin
      start_i  <= 1'b1;
      a_bits_i <= pairs_pending[0].a;
      b_bits_i <= pairs_pending[0].b;
    end else begin
      start_i  <= 1'b0;
      a_bits_i <= {$urandom, $urandom};
      b_bits_i <= {$urandom, $urandom};
    end
  end

  // Monitor. Each done_o cycle is one result transfer, compared with the
  // oldest outstanding expectation. Configuration transfers update our
  // copy of the registers; indices beyond the list are dropped.
  always @(posedge clk_i) begin
    judgement_t want;
    if (done_o) begin
      verdicts_seen <= verdicts_seen + 1;
      if (verdicts_due.size() == 0) begin
        $error("result with nothing outstanding: approx_equal %0b verdict %0d",
               approx_equal_o, verdict_o);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        verd_hits[want.verd] <= verd_hits[want.verd] + 1;
        if (approx_equal_o !== want.eq) begin
          $error("approx_equal: expected %0b, got %0b", want.eq, approx_equal_o);
          errors++;
        end
        if (verdict_o !== want.verd) begin
          $error("verdict: expected %0d, got %0d", want.verd, verdict_o);
          errors++;
        end
      end
    end
    if (cfg_valid_i && cfg_ready_o) begin
      cfg_writes <= cfg_writes + 1;
      if (cfg_index_i == CFG_IDX_TOL) begin
        tol_q <= cfg_data_i[62:0];
      end else if (cfg_index_i == CFG_IDX_ULPS) begin
        ulps_q <= cfg_data_i[15:0];
      end
    end
  end

  // Waits until everything sent has come back, then lets the pipeline drain.
  task automatic drain();
    while (pairs_pending.size() != 0 || verdicts_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= {$urandom, $urandom};
  endtask

  task automatic queue_random(input int count);
    repeat (count) begin
      @(negedge clk_i);
      pairs_pending.push_back(rand_pair());
    end
  endtask

  task automatic queue_pair(input logic [63:0] a, input logic [63:0] b);
    pair_t p;
    p.a = a;
    p.b = b;
    pairs_pending.push_back(p);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pairs under the reset registers: every rule but the relative one, field extremes.
    @(negedge clk_i);
    queue_pair(64'h0, 64'h0);
    queue_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000);
    queue_pair(64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0001);
    queue_pair(64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
    queue_pair(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
    queue_pair(64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    queue_pair(64'h8000_0000_0000_0000, 64'h0);
    queue_pair(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001);
    queue_pair(64'h3FF0_0000_0000_0000, 64'h800F_FFFF_FFFF_FFFF);
    queue_pair(64'h3CD0_0000_0000_0000, 64'h3CD0_0000_0000_0100);
    queue_pair(64'h4340_0000_0000_0000, 64'h4340_0000_0000_0001);
    queue_pair(64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000);
    queue_pair(64'h4000_0000_0000_0000, 64'h4000_0000_0000_0004);
    queue_pair(64'h4000_0000_0000_0000, 64'h4000_0000_0000_0005);
    queue_pair(64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF);
    queue_pair(64'h0010_0000_0000_0000, 64'h0010_0000_0000_0000);
    queue_pair(64'h0, 64'h3FF0_0000_0000_0000);
    queue_pair(64'h0010_0000_0000_0000, 64'h8010_0000_0000_0000);
    drain();

    // Zero tolerance with the smallest ULP limit: identical operands fall
    // through to the relative rule.
    write_reg(CFG_IDX_TOL, 64'h0);
    write_reg(CFG_IDX_ULPS, 64'h0);
    @(negedge clk_i);
    queue_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    queue_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0001);
    queue_random(300);
    drain();

    // Infinite tolerance (sign bit of the data set, which must be dropped)
    // and the largest ULP limit.
    write_reg(CFG_IDX_TOL, 64'hFFF0_0000_0000_0000);
    write_reg(CFG_IDX_ULPS, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_random(250);
    drain();

    // NaN tolerance: the absolute rule can never pass. Writes to the
    // unused indices must change nothing.
    write_reg(CFG_IDX_TOL, 64'h7FF8_0000_0000_0000);
    write_reg(2'd2, 64'h0);
    write_reg(2'd3, 64'h0);
    queue_random(250);
    // Hold the sender back until every outstanding result has arrived.
    hold_off = 1'b1;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    hold_off = 1'b0;
    queue_random(100);
    drain();

    // Largest finite tolerance, then a mid-range one with a random limit.
    write_reg(CFG_IDX_TOL, 64'h7FEF_FFFF_FFFF_FFFF);
    write_reg(CFG_IDX_ULPS, 64'd65535);
    queue_random(200);
    drain();
    write_reg(CFG_IDX_TOL, 64'h3EB0_C6F7_A0B5_ED8D);
    write_reg(CFG_IDX_ULPS, 64'($urandom_range(0, 65535)));
    queue_random(250);
    drain();

    // Back to the reset values.
    write_reg(CFG_IDX_TOL, {1'b0, TOL_RESET});
    write_reg(CFG_IDX_ULPS, {48'd0, ULPS_RESET});
    queue_random(250);
    drain();

    $display("covered %0d pairs, %0d results, %0d register writes", pairs_started,
             verdicts_seen, cfg_writes);
    $display("results per rule nan..not-equal: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             verd_hits[0], verd_hits[1], verd_hits[2], verd_hits[3], verd_hits[4],
             verd_hits[5], verd_hits[6], verd_hits[7], verd_hits[8]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/f64ae_pkg.sv
hw/rtl/f64ae_absdiff.sv
hw/rtl/f64ae_decide.sv
hw/rtl/float64_approx_equal.sv
tb/tb_float64_approx_equal.sv
